FILE: src/crc_ktt_pkg.sv
// Shared types, constants and functions for the CRC keyed tag table.
package crc_ktt_pkg;

   localparam int TABLE_SLOTS = 64;
   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = SLOT_W + 1;

   localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

   // CRC-16/ARC: polynomial 0x8005, processed bit-reflected.
   localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

   typedef enum logic [2:0] {
      MODE_LOOKUP     = 3'd0,
      MODE_ADD        = 3'd1,
      MODE_ITER_FIRST = 3'd2,
      MODE_ITER_NEXT  = 3'd3,
      MODE_CLEAR      = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_NO_MORE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_LOOKUP     = 2'd0,
      OP_ADD        = 2'd1,
      OP_ITER_FIRST = 2'd2,
      OP_ITER_NEXT  = 2'd3
   } op_type;

   typedef struct packed {
      logic   crc_step;
      logic   crc_last;
      logic   scan_start;
      logic   scan_from_cursor;
      op_type scan_op;
      logic   scan_run;
      logic   scan_finish;
      logic   clear_all;
      logic   ld_clear;
      logic   ld_no_more;
      logic   emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic cursor_active;
      logic cursor_at_end;
      logic rsp_free;
   } dp_status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [5:0] slot_field(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W+5:0] ext;
      ext = {6'b000000, idx};
      return ext[5:0];
   endfunction

endpackage

FILE: src/crc_ktt_ctrl.sv
// Controller state machine that sequences topic beats, slot scans and result hand-off.
module crc_ktt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [2:0]                  req_mode,
   input  logic                        req_last_byte,
   output logic                        req_stall,
   input  crc_ktt_pkg::dp_status_type  status,
   output crc_ktt_pkg::ctl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (crc_ktt_pkg::mode_type'(req_mode))
                  crc_ktt_pkg::MODE_LOOKUP, crc_ktt_pkg::MODE_ADD: begin
                     cmd.crc_step = 1'b1;
                     cmd.crc_last = req_last_byte;
                     if (req_last_byte) begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_op    = (req_mode == crc_ktt_pkg::MODE_ADD) ?
                                         crc_ktt_pkg::OP_ADD : crc_ktt_pkg::OP_LOOKUP;
                        state_in       = ST_SCAN;
                     end
                  end
                  crc_ktt_pkg::MODE_ITER_FIRST: begin
                     cmd.scan_start = 1'b1;
                     cmd.scan_op    = crc_ktt_pkg::OP_ITER_FIRST;
                     state_in       = ST_SCAN;
                  end
                  crc_ktt_pkg::MODE_ITER_NEXT: begin
                     if (!status.cursor_active || status.cursor_at_end) begin
                        cmd.ld_no_more = 1'b1;
                        state_in       = ST_EMIT;
                     end else begin
                        cmd.scan_start       = 1'b1;
                        cmd.scan_from_cursor = 1'b1;
                        cmd.scan_op          = crc_ktt_pkg::OP_ITER_NEXT;
                        state_in             = ST_SCAN;
                     end
                  end
                  crc_ktt_pkg::MODE_CLEAR: begin
                     cmd.clear_all = 1'b1;
                     cmd.ld_clear  = 1'b1;
                     state_in      = ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               cmd.scan_finish = 1'b1;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/crc_ktt_datapath.sv
// Datapath: running CRC, slot valid bits, key memory, slot scan pipeline and result registers.
module crc_ktt_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [7:0]                  req_topic_byte,
   input  crc_ktt_pkg::ctl_cmd_type    cmd,
   output crc_ktt_pkg::dp_status_type  status,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [5:0]                  rsp_slot,
   output logic [15:0]                 rsp_topic_crc
);

   logic [15:0]                        running_crc_ff, running_crc_in;
   logic [15:0]                        target_crc_ff, target_crc_in;
   logic [crc_ktt_pkg::TABLE_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [15:0]                        slot_key_ff [crc_ktt_pkg::TABLE_SLOTS];
   logic [15:0]                        key_rd_ff;
   logic [crc_ktt_pkg::SLOT_W-1:0]     cursor_ff, cursor_in;
   logic                               cursor_active_ff, cursor_active_in;
   crc_ktt_pkg::op_type                scan_op_ff, scan_op_in;
   logic [crc_ktt_pkg::CNT_W-1:0]      issue_cnt_ff, issue_cnt_in;
   logic                               probe_live_ff, probe_live_in;
   logic [crc_ktt_pkg::SLOT_W-1:0]     probe_idx_ff, probe_idx_in;
   logic [1:0]                         res_status_ff, res_status_in;
   logic [5:0]                         res_slot_ff, res_slot_in;
   logic [15:0]                        res_crc_ff, res_crc_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic [5:0]                         rsp_slot_ff, rsp_slot_in;
   logic [15:0]                        rsp_topic_crc_ff, rsp_topic_crc_in;

   logic [15:0]                        crc_new;
   logic [crc_ktt_pkg::SLOT_W-1:0]     issue_idx;
   logic                               issue_ok;
   logic                               probe_valid;
   logic                               probe_cond;
   logic                               hit;
   logic                               exhausted;
   logic [crc_ktt_pkg::CNT_W-1:0]      cursor_next;
   logic                               key_wr;

   assign crc_new     = crc_ktt_pkg::crc_byte(running_crc_ff, req_topic_byte);
   assign issue_idx   = issue_cnt_ff[crc_ktt_pkg::SLOT_W-1:0];
   assign issue_ok    = (issue_cnt_ff < crc_ktt_pkg::SLOT_COUNT);
   assign probe_valid = slot_valid_ff[probe_idx_ff];
   assign cursor_next = {1'b0, cursor_ff} + crc_ktt_pkg::CNT_W'(1);

   always_comb begin
      case (scan_op_ff)
         crc_ktt_pkg::OP_ADD:    probe_cond = !probe_valid;
         crc_ktt_pkg::OP_LOOKUP: probe_cond = probe_valid && (key_rd_ff == target_crc_ff);
         default:                probe_cond = probe_valid;
      endcase
   end

   assign hit       = probe_live_ff && probe_cond;
   assign exhausted = probe_live_ff && !probe_cond && (probe_idx_ff == crc_ktt_pkg::SLOT_LAST);

   assign status.scan_done     = hit || exhausted;
   assign status.cursor_active = cursor_active_ff;
   assign status.cursor_at_end = (cursor_ff == crc_ktt_pkg::SLOT_LAST);
   assign status.rsp_free      = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      running_crc_in   = running_crc_ff;
      target_crc_in    = target_crc_ff;
      slot_valid_in    = slot_valid_ff;
      cursor_in        = cursor_ff;
      cursor_active_in = cursor_active_ff;
      scan_op_in       = scan_op_ff;
      issue_cnt_in     = issue_cnt_ff;
      probe_live_in    = probe_live_ff;
      probe_idx_in     = probe_idx_ff;
      res_status_in    = res_status_ff;
      res_slot_in      = res_slot_ff;
      res_crc_in       = res_crc_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_topic_crc_in = rsp_topic_crc_ff;
      key_wr           = 1'b0;

      if (cmd.crc_step) begin
         if (cmd.crc_last) begin
            target_crc_in  = crc_new;
            running_crc_in = 16'h0000;
         end else begin
            running_crc_in = crc_new;
         end
      end

      if (cmd.scan_start) begin
         scan_op_in    = cmd.scan_op;
         issue_cnt_in  = cmd.scan_from_cursor ? cursor_next : '0;
         probe_live_in = 1'b0;
      end

      if (cmd.scan_run) begin
         if (issue_ok) begin
            probe_live_in = 1'b1;
            probe_idx_in  = issue_idx;
            issue_cnt_in  = issue_cnt_ff + crc_ktt_pkg::CNT_W'(1);
         end else begin
            probe_live_in = 1'b0;
         end
      end

      if (cmd.clear_all) begin
         slot_valid_in = '0;
      end

      if (cmd.ld_clear) begin
         res_status_in = crc_ktt_pkg::STATUS_OK;
         res_slot_in   = 6'd0;
         res_crc_in    = 16'h0000;
      end

      if (cmd.ld_no_more) begin
         res_status_in    = crc_ktt_pkg::STATUS_NO_MORE;
         res_slot_in      = 6'd0;
         res_crc_in       = 16'h0000;
         cursor_active_in = 1'b0;
      end

      if (cmd.scan_finish) begin
         if (hit) begin
            res_status_in = crc_ktt_pkg::STATUS_OK;
            res_slot_in   = crc_ktt_pkg::slot_field(probe_idx_ff);
            case (scan_op_ff)
               crc_ktt_pkg::OP_ADD: begin
                  res_crc_in                  = target_crc_ff;
                  slot_valid_in[probe_idx_ff] = 1'b1;
                  key_wr                      = 1'b1;
               end
               crc_ktt_pkg::OP_LOOKUP: begin
                  res_crc_in = target_crc_ff;
               end
               default: begin
                  res_crc_in       = key_rd_ff;
                  cursor_in        = probe_idx_ff;
                  cursor_active_in = 1'b1;
               end
            endcase
         end else begin
            res_slot_in = 6'd0;
            case (scan_op_ff)
               crc_ktt_pkg::OP_ADD: begin
                  res_status_in = crc_ktt_pkg::STATUS_FULL;
                  res_crc_in    = target_crc_ff;
               end
               crc_ktt_pkg::OP_LOOKUP: begin
                  res_status_in = crc_ktt_pkg::STATUS_NOT_FOUND;
                  res_crc_in    = target_crc_ff;
               end
               crc_ktt_pkg::OP_ITER_NEXT: begin
                  res_status_in    = crc_ktt_pkg::STATUS_NO_MORE;
                  res_crc_in       = 16'h0000;
                  cursor_active_in = 1'b0;
               end
               default: begin
                  res_status_in = crc_ktt_pkg::STATUS_NO_MORE;
                  res_crc_in    = 16'h0000;
               end
            endcase
         end
      end

      if (cmd.emit) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = res_status_ff;
         rsp_slot_in      = res_slot_ff;
         rsp_topic_crc_in = res_crc_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff   <= 16'h0000;
         slot_valid_ff    <= '0;
         cursor_ff        <= '0;
         cursor_active_ff <= 1'b0;
         probe_live_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         running_crc_ff   <= running_crc_in;
         slot_valid_ff    <= slot_valid_in;
         cursor_ff        <= cursor_in;
         cursor_active_ff <= cursor_active_in;
         probe_live_ff    <= probe_live_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_crc_ff    <= target_crc_in;
      scan_op_ff       <= scan_op_in;
      issue_cnt_ff     <= issue_cnt_in;
      probe_idx_ff     <= probe_idx_in;
      res_status_ff    <= res_status_in;
      res_slot_ff      <= res_slot_in;
      res_crc_ff       <= res_crc_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_topic_crc_ff <= rsp_topic_crc_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_run && issue_ok) begin
         key_rd_ff <= slot_key_ff[issue_idx];
      end
      if (key_wr) begin
         slot_key_ff[probe_idx_ff] <= target_crc_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_topic_crc = rsp_topic_crc_ff;

endmodule

FILE: src/crc_keyed_tag_table.sv
// Top level of the CRC keyed tag table: controller and datapath.
// The request channel carries one beat per topic byte or command (req_mode,
// req_topic_byte, req_last_byte); the response channel carries one beat per
// completed operation (rsp_status, rsp_slot, rsp_topic_crc).
// A topic byte that is not last updates the running CRC and gives no response.
// A last topic byte, iterate first and iterate next scan the slots through
// the key memory, one slot per cycle starting at the scan origin. Each key
// is read into a register and compared in the probe stage; the deciding
// slot's result is registered, then moved to the response register.
// The scan rate is set by the single read port of the key memory.
// Clear, and iterate next with no cursor left to advance, skip the scan.
// A new request beat is taken once the previous result has moved to the
// response register, so one operation is in flight at a time.
// Reset empties all slots, zeroes the running CRC and drops the cursor.
// While rsp_stall is high the response beat holds, and a finished result
// waits in the block with req_stall high until the response register frees.
module crc_keyed_tag_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_topic_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_slot,
   output logic [15:0] rsp_topic_crc
);

   crc_ktt_pkg::ctl_cmd_type   cmd;
   crc_ktt_pkg::dp_status_type status;

   crc_ktt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_mode      (req_mode),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   crc_ktt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_topic_byte (req_topic_byte),
      .cmd            (cmd),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_topic_crc  (rsp_topic_crc)
   );

endmodule

FILE: dv/crc_keyed_tag_table_test.sv
// Self-checking testbench for crc_keyed_tag_table; it predicts every response with a model of its own.
`timescale 1ns / 100ps

module crc_keyed_tag_table_test;

   localparam logic [15:0] ARC_POLY_REFLECTED = 16'hA001;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam int RANDOM_BEATS = 1600;
   localparam int DRAIN_CYCLES = 150;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 60;
   localparam int TOPIC_POOL_DEPTH = 48;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] data;
      logic       last;
   } request_beat_type;

   typedef struct packed {
      crc_ktt_pkg::status_type status;
      logic [5:0]              slot;
      logic [15:0]             crc;
   } table_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = crc_ktt_pkg::MODE_LOOKUP;
   logic [7:0]  req_topic_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_slot;
   logic [15:0] rsp_topic_crc;

   request_beat_type topic_beats[$];
   table_answer_type answers_due[$];
   logic [63:0]      known_topics[$];
   int               known_lengths[$];

   int counted_beats = 0;
   int total_beats = 0;
   int accepted_beats = 0;
   int failures = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int idle_left = 0;
   int stall_left = 0;
   int stall_style = 0;

   logic [15:0] topic_crc_acc;
   logic        tag_valid[crc_ktt_pkg::TABLE_SLOTS];
   logic [15:0] tag_key[crc_ktt_pkg::TABLE_SLOTS];
   int          walk_cursor;
   logic        walk_active;

   crc_keyed_tag_table DUT (.*);

   always #2 clock = ~clock;

   function automatic logic [15:0] arc_crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      logic        feedback;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         feedback = acc[0] ^ data[i];
         acc = acc >> 1;
         if (feedback) acc = acc ^ ARC_POLY_REFLECTED;
      end
      return acc;
   endfunction

   task automatic apply_to_table(input request_beat_type b);
      logic [15:0]      crc;
      int               hit;
      table_answer_type ans;
      hit = -1;
      ans.status = crc_ktt_pkg::STATUS_OK;
      ans.slot = 6'd0;
      ans.crc = 16'h0000;
      case (b.mode)
         crc_ktt_pkg::MODE_LOOKUP, crc_ktt_pkg::MODE_ADD: begin
            crc = arc_crc_step(topic_crc_acc, b.data);
            if (!b.last) begin
               topic_crc_acc = crc;
               return;
            end
            topic_crc_acc = 16'h0000;
            ans.crc = crc;
            for (int i = 0; i < crc_ktt_pkg::TABLE_SLOTS && hit < 0; i++) begin
               if (b.mode == crc_ktt_pkg::MODE_ADD ? !tag_valid[i]
                                                   : (tag_valid[i] && tag_key[i] == crc))
                  hit = i;
            end
            if (hit < 0) begin
               ans.status = (b.mode == crc_ktt_pkg::MODE_ADD) ? crc_ktt_pkg::STATUS_FULL
                                                              : crc_ktt_pkg::STATUS_NOT_FOUND;
            end else begin
               ans.slot = 6'(hit);
               if (b.mode == crc_ktt_pkg::MODE_ADD) begin
                  tag_valid[hit] = 1'b1;
                  tag_key[hit] = crc;
               end
            end
         end
         crc_ktt_pkg::MODE_ITER_FIRST: begin
            for (int i = 0; i < crc_ktt_pkg::TABLE_SLOTS && hit < 0; i++) begin
               if (tag_valid[i]) hit = i;
            end
            if (hit < 0) begin
               ans.status = crc_ktt_pkg::STATUS_NO_MORE;
            end else begin
               walk_cursor = hit;
               walk_active = 1'b1;
               ans.slot = 6'(hit);
               ans.crc = tag_key[hit];
            end
         end
         crc_ktt_pkg::MODE_ITER_NEXT: begin
            if (walk_active) begin
               for (int i = walk_cursor + 1; i < crc_ktt_pkg::TABLE_SLOTS && hit < 0; i++) begin
                  if (tag_valid[i]) hit = i;
               end
            end
            if (hit < 0) begin
               walk_active = 1'b0;
               ans.status = crc_ktt_pkg::STATUS_NO_MORE;
            end else begin
               walk_cursor = hit;
               ans.slot = 6'(hit);
               ans.crc = tag_key[hit];
            end
         end
         crc_ktt_pkg::MODE_CLEAR: begin
            for (int i = 0; i < crc_ktt_pkg::TABLE_SLOTS; i++) tag_valid[i] = 1'b0;
         end
         default: return;
      endcase
      answers_due.push_back(ans);
   endtask

   task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $error("%s: expected %0h, got %0h", field, want, got);
      end
   endtask

   task automatic queue_beat(input logic [2:0] mode, input logic [7:0] data, input logic last);
      request_beat_type b;
      b.mode = mode;
      b.data = data;
      b.last = last;
      topic_beats.push_back(b);
      if (mode <= crc_ktt_pkg::MODE_CLEAR) counted_beats++;
   endtask

   task automatic queue_noise();
      case ($urandom_range(0, 3))
         0: queue_beat(crc_ktt_pkg::MODE_ITER_NEXT, 8'($urandom), 1'($urandom));
         1: queue_beat(crc_ktt_pkg::MODE_ITER_FIRST, 8'($urandom), 1'($urandom));
         2: queue_beat(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), 8'($urandom),
                       1'($urandom));
         default: queue_beat(crc_ktt_pkg::MODE_CLEAR, 8'($urandom), 1'($urandom));
      endcase
   endtask

   task automatic queue_topic(input logic [2:0] final_mode, input logic [63:0] bytes,
                              input int len, input int noise_pct);
      logic [2:0] mid_mode;
      for (int i = 0; i < len; i++) begin
         if (i != 0 && $urandom_range(0, 99) < noise_pct) queue_noise();
         mid_mode = $urandom_range(0, 1) ? crc_ktt_pkg::MODE_ADD : crc_ktt_pkg::MODE_LOOKUP;
         queue_beat((i == len - 1) ? final_mode : mid_mode, bytes[8*i +: 8], i == len - 1);
      end
   endtask

   task automatic pick_topic(input int reuse_pct, input int max_len,
                             output logic [63:0] bytes, output int len);
      int k;
      if (known_topics.size() != 0 && $urandom_range(0, 99) < reuse_pct) begin
         k = $urandom_range(0, known_topics.size() - 1);
         bytes = known_topics[k];
         len = known_lengths[k];
      end else begin
         bytes = {$urandom, $urandom};
         len = $urandom_range(1, max_len);
         known_topics.push_back(bytes);
         known_lengths.push_back(len);
         if (known_topics.size() > TOPIC_POOL_DEPTH) begin
            void'(known_topics.pop_front());
            void'(known_lengths.pop_front());
         end
      end
   endtask

   initial begin
      logic [63:0] bytes;
      int          len;
      int          pick;
      int          fill_pct;
      int          round_ops;
      int          max_len;
      int          walk;
      int          directed_count;

      topic_crc_acc = 16'h0000;
      walk_cursor = 0;
      walk_active = 1'b0;
      for (int i = 0; i < crc_ktt_pkg::TABLE_SLOTS; i++) begin
         tag_valid[i] = 1'b0;
         tag_key[i] = 16'h0000;
      end

      queue_beat(crc_ktt_pkg::MODE_ITER_FIRST, 8'hA5, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_ITER_NEXT, 8'h5A, 1'b0);
      queue_beat(crc_ktt_pkg::MODE_LOOKUP, 8'h00, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_ADD, 8'hFF, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_LOOKUP, 8'h31, 1'b0);
      queue_beat(crc_ktt_pkg::MODE_ITER_FIRST, 8'h00, 1'b0);
      queue_beat(crc_ktt_pkg::MODE_ADD, 8'h32, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_ADD, 8'hFF, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_LOOKUP, 8'hFF, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_ADD, 8'h80, 1'b0);
      queue_beat(MODE_SPARE_LO, 8'hFF, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_LOOKUP, 8'h01, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_ITER_NEXT, 8'hFF, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_ITER_NEXT, 8'h00, 1'b0);
      queue_beat(crc_ktt_pkg::MODE_ITER_NEXT, 8'hC3, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_ITER_NEXT, 8'h3C, 1'b0);
      queue_beat(crc_ktt_pkg::MODE_ITER_FIRST, 8'hFF, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_CLEAR, 8'hFF, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_ITER_NEXT, 8'h00, 1'b1);
      queue_beat(crc_ktt_pkg::MODE_LOOKUP, 8'hFF, 1'b1);
      queue_beat(MODE_SPARE_HI, 8'h00, 1'b0);
      queue_beat(crc_ktt_pkg::MODE_ITER_FIRST, 8'h00, 1'b0);
      queue_beat(crc_ktt_pkg::MODE_ADD, 8'h00, 1'b1);
      directed_count = counted_beats;

      while (counted_beats < directed_count + RANDOM_BEATS) begin
         if ($urandom_range(0, 2) == 0) begin
            fill_pct = 85;
            round_ops = $urandom_range(60, 150);
            max_len = 2;
         end else begin
            fill_pct = $urandom_range(15, 50);
            round_ops = $urandom_range(4, 60);
            max_len = 8;
         end
         if ($urandom_range(0, 3) != 0)
            queue_beat(crc_ktt_pkg::MODE_CLEAR, 8'($urandom), 1'($urandom));
         repeat (round_ops) begin
            pick = $urandom_range(0, 99);
            if (pick < fill_pct) begin
               pick_topic(30, max_len, bytes, len);
               queue_topic(crc_ktt_pkg::MODE_ADD, bytes, len, 3);
            end else if (pick < fill_pct + (100 - fill_pct) / 2) begin
               pick_topic(75, max_len, bytes, len);
               queue_topic(crc_ktt_pkg::MODE_LOOKUP, bytes, len, 3);
            end else if (pick < 97) begin
               queue_beat(crc_ktt_pkg::MODE_ITER_FIRST, 8'($urandom), 1'($urandom));
               walk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 4);
               repeat (walk)
                  queue_beat(crc_ktt_pkg::MODE_ITER_NEXT, 8'($urandom), 1'($urandom));
            end else begin
               queue_noise();
            end
         end
      end
      total_beats = topic_beats.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_beats != total_beats) @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Sender: bursts of beats separated by idle gaps of random length.
   always @(posedge clock) begin : request_driver
      request_beat_type next_beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            next_beat.mode = req_mode;
            next_beat.data = req_topic_byte;
            next_beat.last = req_last_byte;
            apply_to_table(next_beat);
            accepted_beats++;
         end
         if (!req_valid || !req_stall) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (topic_beats.size() != 0) begin
               next_beat = topic_beats.pop_front();
               req_valid <= 1'b1;
               req_mode <= next_beat.mode;
               req_topic_byte <= next_beat.data;
               req_last_byte <= next_beat.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each response beat and stalls in changing styles.
   always @(posedge clock) begin : response_check
      table_answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("response beat with nothing pending: status %0d slot %0d topic_crc %0h",
                         rsp_status, rsp_slot, rsp_topic_crc);
            end else begin
               want = answers_due.pop_front();
               check_field("rsp_status", 16'(want.status), 16'(rsp_status));
               check_field("rsp_slot", 16'(want.slot), 16'(rsp_slot));
               check_field("rsp_topic_crc", want.crc, rsp_topic_crc);
            end
         end
         if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
         end else begin
            stall_left--;
         end
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_left[1];
         endcase
      end
   end

   always @(posedge clock) begin : run_limit
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

FILE: filelist.f
src/crc_ktt_pkg.sv
src/crc_ktt_ctrl.sv
src/crc_ktt_datapath.sv
src/crc_keyed_tag_table.sv
dv/crc_keyed_tag_table_test.sv
